// ===== rtl/core/lapf3_pkg.sv =====
// ----------------------------------------------------------------------------
// lapf3_pkg
// Shared constants and codes for the 3x3 four-neighbour Laplacian filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lapf3_pkg;

  localparam int MAX_WIDTH       = 1024;
  localparam int PIXEL_BITS      = 8;
  localparam int MAX_HEIGHT      = 4096;

  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 13;
  localparam int CFG_DATA_BITS   = 13;
  localparam int CFG_INDEX_BITS  = 1;

  localparam int RESET_WIDTH     = 64;
  localparam int RESET_HEIGHT    = 64;

  // output row counts 0..MAX_HEIGHT-1, input row runs one or two past the frame
  localparam int ROW_BITS        = $clog2(MAX_HEIGHT);
  localparam int IN_ROW_BITS     = ROW_BITS + 1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_t;

endpackage

`default_nettype wire

// ===== rtl/core/lapf3_linebuf.sv =====
// ----------------------------------------------------------------------------
// lapf3_linebuf
// Line store: one synchronous memory, one write and one read port, read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module lapf3_linebuf #(
  parameter int DEPTH     = lapf3_pkg::MAX_WIDTH,
  parameter int DATA_BITS = 2 * lapf3_pkg::PIXEL_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic      [DATA_BITS-1:0]         rd_data,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire logic [DATA_BITS-1:0]         wr_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/laplacian_filter_3x3.sv =====
// ----------------------------------------------------------------------------
// laplacian_filter_3x3
// Four-neighbour Laplacian (4*centre - up - down - left - right) over a raster
// pixel stream, clamped to 0..255, with neighbours outside the image as zero.
// ----------------------------------------------------------------------------
// Takes one word per clock and gives at most one result word per clock while
// the master side does not stall. Each result leaves one row plus one pixel
// after its centre pixel went in; after the last pixel of a frame, send
// width+1 flush words (tuser = 1) to drain it. An accepted word is registered
// with its line-store read, then in the output register. The two previous
// rows live in one memory of MAX_WIDTH entries, read and written back once
// per word; a forwarding path covers a one-pixel-wide image where consecutive
// words hit the same entry. The memory is never cleared: entries not yet
// written only ever feed masked neighbours. A register write restarts the
// frame; write only while the block is idle, which it does not itself enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_filter_3x3 #(
  parameter int MAX_WIDTH  = lapf3_pkg::MAX_WIDTH,
  parameter int PIXEL_BITS = lapf3_pkg::PIXEL_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,

  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [PIXEL_BITS-1:0]                 s_tdata,   // [7:0] pixel
  input  wire logic                                  s_tuser,   // [0] kind

  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic      [PIXEL_BITS-1:0]                 m_tdata,   // [7:0] edge_value
  output logic                                       m_tlast,   // row_end
  output logic                                       m_tuser,   // [0] frame_end

  input  wire logic                                  cfg_we,
  input  wire logic [lapf3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [lapf3_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = lapf3_pkg::ROW_BITS;
  localparam int IN_ROW_BITS = lapf3_pkg::IN_ROW_BITS;
  localparam int SUM_BITS    = PIXEL_BITS + 4;
  localparam int RESET_W_EFF = (lapf3_pkg::RESET_WIDTH > MAX_WIDTH) ?
                               MAX_WIDTH : lapf3_pkg::RESET_WIDTH;
  localparam logic [COL_BITS-1:0] RESET_W_LAST = COL_BITS'(RESET_W_EFF - 1);
  localparam logic [ROW_BITS-1:0] RESET_H_LAST = ROW_BITS'(lapf3_pkg::RESET_HEIGHT - 1);
  localparam logic [COL_BITS-1:0] MAX_W_LAST   = COL_BITS'(MAX_WIDTH - 1);
  localparam logic [ROW_BITS-1:0] MAX_H_LAST   = ROW_BITS'(lapf3_pkg::MAX_HEIGHT - 1);
  localparam logic [PIXEL_BITS-1:0] PIX_MAX    = {PIXEL_BITS{1'b1}};

  typedef struct packed {
    logic emit;
    logic up_ok;
    logic dn_ok;
    logic lf_ok;
    logic rt_ok;
    logic rend;
    logic fend;
  } ctrl_t;

  // ---------------------------------------------------------------- config
  logic [COL_BITS-1:0]                        w_last;
  logic [ROW_BITS-1:0]                        h_last;
  logic [COL_BITS-1:0]                        w_last_next;
  logic [ROW_BITS-1:0]                        h_last_next;
  logic [lapf3_pkg::WIDTH_REG_BITS-1:0]       cfg_w;
  logic [lapf3_pkg::HEIGHT_REG_BITS-1:0]      cfg_h;

  assign cfg_w = cfg_wdata[lapf3_pkg::WIDTH_REG_BITS-1:0];
  assign cfg_h = cfg_wdata[lapf3_pkg::HEIGHT_REG_BITS-1:0];

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (cfg_w == '0) begin
      w_last_next = '0;
    end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
      w_last_next = MAX_W_LAST;
    end else begin
      w_last_next = COL_BITS'(32'(cfg_w) - 32'd1);
    end
    if (cfg_h == '0) begin
      h_last_next = '0;
    end else if (32'(cfg_h) > 32'(lapf3_pkg::MAX_HEIGHT)) begin
      h_last_next = MAX_H_LAST;
    end else begin
      h_last_next = ROW_BITS'(32'(cfg_h) - 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= RESET_W_LAST;
      h_last <= RESET_H_LAST;
    end else if (cfg_we) begin
      case (lapf3_pkg::cfg_reg_t'(cfg_index))
        lapf3_pkg::REG_IMAGE_WIDTH:  w_last <= w_last_next;
        lapf3_pkg::REG_IMAGE_HEIGHT: h_last <= h_last_next;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- stage 0: control
  logic [COL_BITS-1:0]    in_col;
  logic [IN_ROW_BITS-1:0] in_row;
  logic [COL_BITS-1:0]    out_col;
  logic [ROW_BITS-1:0]    out_row;
  logic                   frame_done;

  logic                   accept;
  logic                   take;
  ctrl_t                  ctrl;
  logic [PIXEL_BITS-1:0]  val;
  logic                   in_row_end;

  // stage 1 registers
  logic                   s1_valid;
  ctrl_t                  s1_ctrl;
  logic [COL_BITS-1:0]    s1_col;
  logic [PIXEL_BITS-1:0]  s1_val;
  logic                   s1_fwd;
  logic [PIXEL_BITS-1:0]  s1_fwd_top;
  logic [PIXEL_BITS-1:0]  s1_fwd_mid;
  logic                   s1_adv;

  logic [2*PIXEL_BITS-1:0] rd_data;
  logic [PIXEL_BITS-1:0]   top_e;
  logic [PIXEL_BITS-1:0]   mid_e;

  assign s1_adv   = s1_valid && (!s1_ctrl.emit || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;
  // flush during the pixel phase is dropped; a pixel while draining is a flush
  assign take     = accept && (frame_done || lapf3_pkg::kind_t'(s_tuser) == lapf3_pkg::KIND_PIXEL);
  assign val      = frame_done ? '0 : s_tdata;
  assign in_row_end = (in_col == w_last);

  always_comb begin
    ctrl.emit  = (in_row > IN_ROW_BITS'(1)) || (in_row == IN_ROW_BITS'(1) && in_col != '0);
    ctrl.up_ok = (out_row != '0);
    ctrl.dn_ok = (out_row != h_last);
    ctrl.lf_ok = (out_col != '0);
    ctrl.rt_ok = (out_col != w_last);
    ctrl.rend  = (out_col == w_last);
    ctrl.fend  = ctrl.emit && ctrl.rend && (out_row == h_last);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      in_col     <= '0;
      in_row     <= '0;
      out_col    <= '0;
      out_row    <= '0;
      frame_done <= 1'b0;
    end else if (take) begin
      if (ctrl.fend) begin
        in_col     <= '0;
        in_row     <= '0;
        out_col    <= '0;
        out_row    <= '0;
        frame_done <= 1'b0;
      end else begin
        if (ctrl.emit) begin
          if (ctrl.rend) begin
            out_col <= '0;
            out_row <= out_row + ROW_BITS'(1);
          end else begin
            out_col <= out_col + COL_BITS'(1);
          end
        end
        if (in_row_end) begin
          in_col <= '0;
          in_row <= in_row + IN_ROW_BITS'(1);
          if (in_row == {1'b0, h_last}) begin
            frame_done <= 1'b1;
          end
        end else begin
          in_col <= in_col + COL_BITS'(1);
        end
      end
    end
  end

  // ---------------------------------------------------- line store (r-m-w)
  lapf3_linebuf #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (2 * PIXEL_BITS)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (in_col),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data ({mid_e, s1_val})
  );

  // forwarded data wins when the word ahead wrote the same entry on the read edge
  assign top_e = s1_fwd ? s1_fwd_top : rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
  assign mid_e = s1_fwd ? s1_fwd_mid : rd_data[PIXEL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_ctrl    <= ctrl;
      s1_col     <= in_col;
      s1_val     <= val;
      s1_fwd     <= s1_adv && (s1_col == in_col);
      s1_fwd_top <= mid_e;
      s1_fwd_mid <= s1_val;
    end
  end

  // -------------------------------------------------- stage 1: window, sum
  logic [PIXEL_BITS-1:0]       win_top;
  logic [PIXEL_BITS-1:0]       win_mid;
  logic [PIXEL_BITS-1:0]       win_bot;
  logic [PIXEL_BITS-1:0]       win_left;

  logic [PIXEL_BITS-1:0]       up_px;
  logic [PIXEL_BITS-1:0]       dn_px;
  logic [PIXEL_BITS-1:0]       lf_px;
  logic [PIXEL_BITS-1:0]       rt_px;
  logic signed [SUM_BITS-1:0]  sum;
  logic [PIXEL_BITS-1:0]       edge_clamped;

  assign up_px = s1_ctrl.up_ok ? win_top  : '0;
  assign dn_px = s1_ctrl.dn_ok ? win_bot  : '0;
  assign lf_px = s1_ctrl.lf_ok ? win_left : '0;
  assign rt_px = s1_ctrl.rt_ok ? mid_e    : '0;

  always_comb begin
    sum = $signed({2'b00, win_mid, 2'b00})
        - $signed({4'b0000, up_px})
        - $signed({4'b0000, dn_px})
        - $signed({4'b0000, lf_px})
        - $signed({4'b0000, rt_px});
    if (sum[SUM_BITS-1]) begin
      edge_clamped = '0;
    end else if (|sum[SUM_BITS-2:PIXEL_BITS]) begin
      edge_clamped = PIX_MAX;
    end else begin
      edge_clamped = sum[PIXEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      win_top  <= '0;
      win_mid  <= '0;
      win_bot  <= '0;
      win_left <= '0;
    end else if (s1_adv) begin
      if (s1_ctrl.fend) begin
        win_top  <= '0;
        win_mid  <= '0;
        win_bot  <= '0;
        win_left <= '0;
      end else begin
        win_top  <= top_e;
        win_mid  <= mid_e;
        win_bot  <= s1_val;
        win_left <= win_mid;
      end
    end
  end

  // ------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && s1_ctrl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctrl.emit) begin
      m_tdata <= edge_clamped;
      m_tlast <= s1_ctrl.rend;
      m_tuser <= s1_ctrl.fend;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_laplacian_filter_3x3.sv =====
// ----------------------------------------------------------------------------
// tb_laplacian_filter_3x3
// Self-checking bench for the four-neighbour Laplacian stream filter.
// ----------------------------------------------------------------------------
// Drives raster frames of many geometries through the slave stream and keeps
// its own pixel-level model of the line stores, window and counters. Each
// accepted word updates the model; the expected results are queued and
// compared field by field with the words leaving the master stream. Part of a
// frame at reset geometry comes first, then a short table of hand-worked
// frames, random noisy frames with cut-short drains, then a short oversize burst.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_laplacian_filter_3x3;

  localparam int RESET_CYCLES    = 4;
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_CYCLES     = 300;
  localparam int STALL_LIMIT     = 3000;
  localparam int RANDOM_PIXELS   = 1250;
  localparam int OVERSIZE_PIXELS = 40;
  localparam int DIR_ROWS        = 23;

  localparam lapf3_pkg::cfg_reg_t REG_W   = lapf3_pkg::REG_IMAGE_WIDTH;
  localparam lapf3_pkg::cfg_reg_t REG_H   = lapf3_pkg::REG_IMAGE_HEIGHT;
  localparam lapf3_pkg::kind_t    K_PIX   = lapf3_pkg::KIND_PIXEL;
  localparam lapf3_pkg::kind_t    K_FLUSH = lapf3_pkg::KIND_FLUSH;

  typedef struct packed {
    logic [7:0] edge_value;
    logic       row_end;
    logic       frame_end;
  } edge_word_t;

  typedef struct packed {
    bit                                  set_reg;
    lapf3_pkg::cfg_reg_t                 reg_sel;
    logic [lapf3_pkg::CFG_DATA_BITS-1:0] reg_val;
    lapf3_pkg::kind_t                    kind;
    logic [7:0]                          pixel;
    bit                                  typed;
    edge_word_t                          result;
  } dir_row_t;

  localparam edge_word_t NO_WORD = '0;

  logic                                 clk;
  logic                                 rst;
  logic                                 s_tvalid;
  logic                                 s_tready;
  logic [7:0]                           s_tdata;   // [7:0] pixel
  logic                                 s_tuser;   // [0] kind
  logic                                 m_tvalid;
  logic                                 m_tready;
  logic [7:0]                           m_tdata;   // [7:0] edge_value
  logic                                 m_tlast;   // row_end
  logic                                 m_tuser;   // [0] frame_end
  logic                                 cfg_we;
  logic [lapf3_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [lapf3_pkg::CFG_DATA_BITS-1:0]  cfg_wdata;

  // travel with the word on the slave side: a hand-worked result, if any
  logic       word_typed;
  edge_word_t word_result;

  bit rx_hold_req = 1'b0;
  bit rx_calm     = 1'b0;
  bit tx_calm     = 1'b0;
  int mismatch_count = 0;
  int pixels_sent    = 0;

  edge_word_t pending_edges [$];

  // model state
  logic [lapf3_pkg::WIDTH_REG_BITS-1:0]  width_q;
  logic [lapf3_pkg::HEIGHT_REG_BITS-1:0] height_q;
  logic [7:0] up_line  [lapf3_pkg::MAX_WIDTH];
  logic [7:0] mid_line [lapf3_pkg::MAX_WIDTH];
  logic [7:0] win [6];  // 0..2: column c-1 top..bottom, 3..5: column c-2
  int in_col, in_row, out_col, out_row;
  bit draining;

  // 3x3 frame of extremes, then a 1x1 frame set up with zero registers
  dir_row_t dir_table [DIR_ROWS] = '{
    '{1'b1, REG_H == REG_W ? REG_W : REG_W, 13'd3, K_PIX, 8'd0, 1'b0, NO_WORD},
    '{1'b1, REG_H,  13'd3, K_PIX,   8'd0,   1'b0, NO_WORD},
    '{1'b0, REG_W,  13'd0, K_FLUSH, 8'd0,   1'b0, NO_WORD},
    '{1'b0, REG_W,  13'd0, K_PIX,   8'd255, 1'b0, NO_WORD},
    '{1'b0, REG_W,  13'd0, K_PIX,   8'd0,   1'b0, NO_WORD},
    '{1'b0, REG_W,  13'd0, K_PIX,   8'd255, 1'b0, NO_WORD},
    '{1'b0, REG_W,  13'd0, K_PIX,   8'd0,   1'b0, NO_WORD},
    '{1'b0, REG_W,  13'd0, K_PIX,   8'd60,  1'b1, '{8'd255, 1'b0, 1'b0}},
    '{1'b0, REG_W,  13'd0, K_PIX,   8'd0,   1'b1, '{8'd0,   1'b0, 1'b0}},
    '{1'b0, REG_W,  13'd0, K_PIX,   8'd255, 1'b1, '{8'd255, 1'b1, 1'b0}},
    '{1'b0, REG_W,  13'd0, K_PIX,   8'd0,   1'b1, '{8'd0,   1'b0, 1'b0}},
    '{1'b0, REG_W,  13'd0, K_PIX,   8'd255, 1'b1, '{8'd240, 1'b0, 1'b0}},
    '{1'b0, REG_W,  13'd0, K_FLUSH, 8'd0,   1'b1, '{8'd0,   1'b1, 1'b0}},
    '{1'b0, REG_W,  13'd0, K_PIX,   8'd77,  1'b1, '{8'd255, 1'b0, 1'b0}},
    '{1'b0, REG_W,  13'd0, K_FLUSH, 8'd0,   1'b1, '{8'd0,   1'b0, 1'b0}},
    '{1'b0, REG_W,  13'd0, K_FLUSH, 8'd0,   1'b1, '{8'd255, 1'b1, 1'b1}},
    '{1'b0, REG_W,  13'd0, K_FLUSH, 8'd0,   1'b0, NO_WORD},
    '{1'b1, REG_W,  13'd0, K_PIX,   8'd0,   1'b0, NO_WORD},
    '{1'b1, REG_H,  13'd0, K_PIX,   8'd0,   1'b0, NO_WORD},
    '{1'b0, REG_W,  13'd0, K_PIX,   8'd50,  1'b0, NO_WORD},
    '{1'b0, REG_W,  13'd0, K_FLUSH, 8'd0,   1'b0, NO_WORD},
    '{1'b0, REG_W,  13'd0, K_FLUSH, 8'd0,   1'b1, '{8'd200, 1'b1, 1'b1}},
    '{1'b0, REG_W,  13'd0, K_PIX,   8'd255, 1'b0, NO_WORD}
  };

  laplacian_filter_3x3 dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int clamp_width(input logic [lapf3_pkg::WIDTH_REG_BITS-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > lapf3_pkg::MAX_WIDTH) return lapf3_pkg::MAX_WIDTH;
    return int'(v);
  endfunction

  function automatic int clamp_height(input logic [lapf3_pkg::HEIGHT_REG_BITS-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > lapf3_pkg::MAX_HEIGHT) return lapf3_pkg::MAX_HEIGHT;
    return int'(v);
  endfunction

  function automatic void restart_frame_state();
    for (int k = 0; k < 6; k++) win[k] = '0;
    in_col   = 0;
    in_row   = 0;
    out_col  = 0;
    out_row  = 0;
    draining = 1'b0;
  endfunction

  // Append one expected word at the tail of the queue.
  function automatic void enqueue_edge(input edge_word_t e);
    pending_edges = {pending_edges, e};
  endfunction

  // Advance the model by one accepted word; return 1 when it yields a result.
  function automatic bit laplace_step(input lapf3_pkg::kind_t k, input logic [7:0] px,
                                      output edge_word_t res);
    int w, h, col, total, c_px, up_px, dn_px, lf_px, rt_px;
    logic [7:0] top_px, mid_px, new_px;
    bit emit;
    res = '0;
    w = clamp_width(width_q);
    h = clamp_height(height_q);
    if (!draining && k == K_FLUSH) return 1'b0;
    new_px = draining ? 8'd0 : px;

    col = in_col % lapf3_pkg::MAX_WIDTH;
    top_px = up_line[col];
    mid_px = mid_line[col];
    up_line[col]  = mid_px;
    mid_line[col] = new_px;

    emit = in_row > 1 || (in_row == 1 && in_col >= 1);
    if (emit) begin
      c_px  = int'(win[1]);
      up_px = (out_row > 0)     ? int'(win[0]) : 0;
      dn_px = (out_row + 1 < h) ? int'(win[2]) : 0;
      lf_px = (out_col > 0)     ? int'(win[4]) : 0;
      rt_px = (out_col + 1 < w) ? int'(mid_px) : 0;
      total = 4 * c_px - up_px - dn_px - lf_px - rt_px;
      if (total < 0) total = 0;
      if (total > 255) total = 255;
      res.edge_value = total[7:0];
      res.row_end    = (out_col + 1 >= w);
      res.frame_end  = res.row_end && (out_row + 1 >= h);
      if (res.frame_end) begin
        restart_frame_state();
        return 1'b1;
      end
      if (res.row_end) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    end

    win[3] = win[0];
    win[4] = win[1];
    win[5] = win[2];
    win[0] = top_px;
    win[1] = mid_px;
    win[2] = new_px;

    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!draining && in_row >= h) draining = 1'b1;
    return emit;
  endfunction

  always @(posedge clk) begin : scoreboard
    edge_word_t want;
    edge_word_t predicted;
    bit hit;
    if (rst) begin
      width_q  = lapf3_pkg::RESET_WIDTH[lapf3_pkg::WIDTH_REG_BITS-1:0];
      height_q = lapf3_pkg::RESET_HEIGHT[lapf3_pkg::HEIGHT_REG_BITS-1:0];
      for (int k = 0; k < lapf3_pkg::MAX_WIDTH; k++) begin
        up_line[k]  = '0;
        mid_line[k] = '0;
      end
      restart_frame_state();
      pending_edges.delete();
    end else begin
      // check the outgoing word before the incoming one is modeled
      if (m_tvalid && m_tready) begin
        if (pending_edges.size() == 0) begin
          $error("unexpected result word: edge_value %0d row_end %0b frame_end %0b",
                 m_tdata, m_tlast, m_tuser);
          mismatch_count++;
        end else begin
          want = pending_edges.pop_front();
          if (m_tdata !== want.edge_value) begin
            $error("edge_value: expected %0d, got %0d", want.edge_value, m_tdata);
            mismatch_count++;
          end
          if (m_tlast !== want.row_end) begin
            $error("row_end: expected %0b, got %0b", want.row_end, m_tlast);
            mismatch_count++;
          end
          if (m_tuser !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, m_tuser);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) begin
        case (lapf3_pkg::cfg_reg_t'(cfg_index))
          REG_W:   width_q  = cfg_wdata[lapf3_pkg::WIDTH_REG_BITS-1:0];
          REG_H:   height_q = cfg_wdata[lapf3_pkg::HEIGHT_REG_BITS-1:0];
          default: ;
        endcase
        restart_frame_state();
      end
      if (s_tvalid && s_tready) begin
        hit = laplace_step(lapf3_pkg::kind_t'(s_tuser), s_tdata, predicted);
        if (word_typed) enqueue_edge(word_result);
        else if (hit) enqueue_edge(predicted);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || rst) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2, 3: return 8'($urandom_range(100, 140));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Result side: random stalls, calm stretches, and one long hold on request.
  initial begin : sink
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic push_word(input lapf3_pkg::kind_t k, input logic [7:0] px,
                           input bit typed, input edge_word_t result);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid    <= 1'b1;
    s_tuser     <= k;
    s_tdata     <= px;
    word_typed  <= typed;
    word_result <= result;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Hold the sender until every expected word is out and the pipe is empty.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_geometry(input lapf3_pkg::cfg_reg_t sel,
                                input logic [lapf3_pkg::CFG_DATA_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Send pix_count pixels of a w x h frame with stray flush words mixed in;
  // a complete frame is followed by its drain, now and then cut short.
  task automatic stream_frame(input int w, input int h, input int pix_count);
    int drain;
    for (int n = 0; n < pix_count; n++) begin
      if ($urandom_range(0, 39) == 0) push_word(K_FLUSH, pick_pixel(), 1'b0, NO_WORD);
      push_word(K_PIX, pick_pixel(), 1'b0, NO_WORD);
      pixels_sent++;
    end
    if (pix_count == w * h) begin
      drain = w + 1;
      if (drain >= 3 && $urandom_range(0, 19) == 0) drain -= $urandom_range(1, 2);
      for (int n = 0; n < drain; n++) begin
        // a pixel while draining only counts as a flush
        if ($urandom_range(0, 3) == 0) push_word(K_PIX, pick_pixel(), 1'b0, NO_WORD);
        else push_word(K_FLUSH, pick_pixel(), 1'b0, NO_WORD);
      end
      if ($urandom_range(0, 9) == 0) push_word(K_FLUSH, pick_pixel(), 1'b0, NO_WORD);
    end
  endtask

  initial begin : stimulus
    int w_val, h_val, ew, eh, frames, pix;
    rst         <= 1'b1;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= K_PIX;
    word_typed  <= 1'b0;
    word_result <= NO_WORD;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_W;
    cfg_wdata   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset geometry, part of a frame; the long hold makes the input stall
    tx_calm = 1'b1;
    rx_hold_req = 1'b1;
    stream_frame(lapf3_pkg::RESET_WIDTH, lapf3_pkg::RESET_HEIGHT, 200);
    tx_calm = 1'b0;
    drain_results();

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].set_reg) begin
        drain_results();
        write_geometry(dir_table[i].reg_sel, dir_table[i].reg_val);
      end else begin
        push_word(dir_table[i].kind, dir_table[i].pixel,
                  dir_table[i].typed, dir_table[i].result);
      end
    end
    drain_results();

    pixels_sent = 0;
    while (pixels_sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 7))
        0: w_val = $urandom_range(0, 2);
        1: w_val = $urandom_range(17, 40);
        default: w_val = $urandom_range(3, 16);
      endcase
      h_val   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      write_geometry(REG_W, w_val[lapf3_pkg::CFG_DATA_BITS-1:0]);
      write_geometry(REG_H, h_val[lapf3_pkg::CFG_DATA_BITS-1:0]);
      ew = clamp_width(w_val[lapf3_pkg::WIDTH_REG_BITS-1:0]);
      eh = clamp_height(h_val[lapf3_pkg::HEIGHT_REG_BITS-1:0]);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        pix = ew * eh;
        // leave the last frame unfinished now and then; the next write restarts it
        if (f == frames - 1 && $urandom_range(0, 4) == 0) pix = $urandom_range(1, pix);
        stream_frame(ew, eh, pix);
      end
      drain_results();
    end

    // oversize registers clamp to the largest frame; send only its first pixels
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    write_geometry(REG_W, 13'd2047);
    write_geometry(REG_H, 13'd8191);
    stream_frame(lapf3_pkg::MAX_WIDTH, lapf3_pkg::MAX_HEIGHT, OVERSIZE_PIXELS);
    drain_results();

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/lapf3_pkg.sv
rtl/core/lapf3_linebuf.sv
rtl/core/laplacian_filter_3x3.sv
test/tb_laplacian_filter_3x3.sv
